>>> rtl/rsla_pkg.sv
package rsla_pkg;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_STATUS = 2'd1,
    OP_COLOUR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_FLASH   = 2'd1,
    KIND_PULSE   = 2'd2,
    KIND_BREATHE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    DIV_MOD,
    DIV_PHASE,
    DIV_FLASH
  } div_ph_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_RUN,
    ST_DIV_DONE,
    ST_BFACT,
    ST_SQ_MUL,
    ST_SQ_DIV,
    ST_SHADE_MUL,
    ST_SHADE_WR,
    ST_RESTART,
    ST_BRIGHT_MUL,
    ST_BRIGHT_WR,
    ST_OUT
  } st_e;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_UPDATE_PERIOD = 2'd1;

  localparam logic [7:0] BRIGHTNESS_RST    = 8'd255;
  localparam logic [7:0] UPDATE_PERIOD_RST = 8'd20;

  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    kind_e       kind;
    logic [15:0] dur;
    logic        cont;
  } status_entry_t;

  localparam status_entry_t STATUS_ROM [16] = '{
    '{8'd0,   8'd0,   8'd0,   KIND_NONE,  16'd0,    1'b0},
    '{8'd255, 8'd255, 8'd255, KIND_FLASH, 16'd500,  1'b1},
    '{8'd255, 8'd255, 8'd255, KIND_PULSE, 16'd2000, 1'b1},
    '{8'd255, 8'd255, 8'd255, KIND_NONE,  16'd0,    1'b0},
    '{8'd0,   8'd0,   8'd255, KIND_PULSE, 16'd2000, 1'b1},
    '{8'd255, 8'd165, 8'd0,   KIND_PULSE, 16'd2000, 1'b1},
    '{8'd0,   8'd0,   8'd255, KIND_NONE,  16'd0,    1'b0},
    '{8'd255, 8'd0,   8'd40,  KIND_FLASH, 16'd300,  1'b1},
    '{8'd0,   8'd255, 8'd40,  KIND_FLASH, 16'd300,  1'b1},
    '{8'd220, 8'd0,   8'd220, KIND_PULSE, 16'd2000, 1'b1},
    '{8'd220, 8'd0,   8'd220, KIND_FLASH, 16'd2000, 1'b1},
    '{8'd0,   8'd0,   8'd0,   KIND_NONE,  16'd0,    1'b0},
    '{8'd0,   8'd0,   8'd0,   KIND_NONE,  16'd0,    1'b0},
    '{8'd0,   8'd0,   8'd0,   KIND_NONE,  16'd0,    1'b0},
    '{8'd0,   8'd0,   8'd0,   KIND_NONE,  16'd0,    1'b0},
    '{8'd0,   8'd0,   8'd0,   KIND_NONE,  16'd0,    1'b0}
  };

  localparam logic [7:0] QSINE [65] = '{
    8'd0,   8'd6,   8'd13,  8'd19,  8'd25,  8'd31,  8'd37,  8'd44,
    8'd50,  8'd56,  8'd62,  8'd68,  8'd74,  8'd80,  8'd86,  8'd92,
    8'd98,  8'd103, 8'd109, 8'd115, 8'd120, 8'd126, 8'd131, 8'd136,
    8'd142, 8'd147, 8'd152, 8'd157, 8'd162, 8'd167, 8'd171, 8'd176,
    8'd180, 8'd185, 8'd189, 8'd193, 8'd197, 8'd201, 8'd205, 8'd208,
    8'd212, 8'd215, 8'd219, 8'd222, 8'd225, 8'd228, 8'd231, 8'd233,
    8'd236, 8'd238, 8'd240, 8'd242, 8'd244, 8'd246, 8'd247, 8'd249,
    8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd254, 8'd255, 8'd255,
    8'd255
  };

  // magnitude of sine at turn step t; the sign is t[7]
  function automatic logic [7:0] sine_mag(input logic [7:0] t);
    logic [6:0] idx;
    idx = t[6] ? (7'd64 - {1'b0, t[5:0]}) : {1'b0, t[5:0]};
    return QSINE[idx];
  endfunction

  // floor(p / 255) for p <= 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

>>> rtl/rgb_status_led_animator_core.sv
// Tick without an update, select status, reserved op: no result; the block stays idle.
// Update without animation or set colour: brightness scaling of each channel, then the result.
// Flash update: one division first; pulse: remainder then phase division; breathe: as pulse plus a squaring,
//   all on the one-bit-per-cycle shared divider (NUM_W = 32 by default).
// One item at a time; a new item is taken while a result waits in the output register.
// Async active-low reset restores register defaults and the off state; no clearing pass.
module rgb_status_led_animator_core
  import rsla_pkg::*;
#(
  parameter int SINE_STEPS    = 256,
  parameter int STATUS_COUNT  = 11,
  parameter int ELAPSED_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [31:0]            s_axis_tdata,  // status_code, red_in, green_in, blue_in
  input  logic [1:0]             s_axis_tuser,  // operation
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [23:0]            m_axis_tdata,  // red_duty, green_duty, blue_duty
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [7:0]             cfg_data_i
);

  localparam int SW    = $clog2(SINE_STEPS + 1);
  localparam int NUM_W = (ELAPSED_WIDTH > 16 + SW) ? ELAPSED_WIDTH : 16 + SW;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int EW    = ELAPSED_WIDTH;
  // t = k * 256 / SINE_STEPS by reciprocal, exact for k < SINE_STEPS
  localparam int         TURN_SH  = 21;
  localparam logic [25:0] TURN_MUL = 26'(((1 << 29) + SINE_STEPS - 1) / SINE_STEPS);

  st_e                state_q, state_d;
  div_ph_e            ph_q, ph_d;
  logic [7:0]         bright_q, bright_d;
  logic [7:0]         period_q, period_d;
  logic [3:0]         cur_q, cur_d;
  logic [7:0]         target_q [3];
  logic [7:0]         target_d [3];
  logic [7:0]         shown_q [3];
  logic [7:0]         shown_d [3];
  logic [7:0]         duty_q [3];
  logic [7:0]         duty_d [3];
  kind_e              kind_q, kind_d;
  logic [15:0]        dur_q, dur_d;
  logic               cont_q, cont_d;
  logic               anim_q, anim_d;
  logic [7:0]         upd_q, upd_d;
  logic [EW-1:0]      e_q, e_d;
  logic [NUM_W-1:0]   num_q, num_d;
  logic [15:0]        den_q, den_d;
  logic [15:0]        rem_q, rem_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]         ch_q, ch_d;
  logic [7:0]         t_q, t_d;
  logic [7:0]         b_q, b_d;
  logic [15:0]        prod_q, prod_d;
  logic               ovalid_q, ovalid_d;
  logic [23:0]        odata_q, odata_d;

  logic               in_acc;
  op_e                op;
  logic [3:0]         code;
  logic [7:0]         upd_inc;
  logic               upd_hit;
  logic [EW-1:0]      e_inc;
  logic [16:0]        trial;
  logic               qbit;
  logic [7:0]         mul_a, mul_b;
  logic [7:0]         tmag;
  logic [8:0]         pulse_sum;
  logic [35:0]        turn_prod;
  status_entry_t      entry;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign op            = op_e'(s_axis_tuser);
  assign code          = s_axis_tdata[3:0];
  assign upd_inc       = (upd_q == 8'd255) ? upd_q : upd_q + 8'd1;
  assign upd_hit       = (upd_inc >= period_q);
  assign e_inc         = e_q + EW'(1);
  assign entry         = STATUS_ROM[({1'b0, code} < 5'(STATUS_COUNT)) ? code : 4'd0];
  assign trial         = {rem_q, num_q[NUM_W-1]};
  assign qbit          = (trial >= {1'b0, den_q});
  assign tmag          = sine_mag(t_q);
  assign pulse_sum     = t_q[7] ? (9'd255 - {1'b0, tmag}) : (9'd255 + {1'b0, tmag});
  assign turn_prod     = {26'd0, num_q[9:0]} * {10'd0, TURN_MUL};
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  // shared multiplier operands
  always_comb begin
    case (state_q)
      ST_SQ_MUL: begin
        mul_a = sine_mag({1'b0, t_q[7:1]});
        mul_b = sine_mag({1'b0, t_q[7:1]});
      end
      ST_SHADE_MUL: begin
        mul_a = target_q[ch_q];
        mul_b = b_q;
      end
      default: begin
        mul_a = shown_q[ch_q];
        mul_b = bright_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_TICK: begin
              if (upd_hit) begin
                if (!anim_q) begin
                  state_d = ST_BRIGHT_MUL;
                end else if (kind_q == KIND_FLASH) begin
                  state_d = (dur_q[15:1] == 15'd0) ? ST_RESTART : ST_DIV_RUN;
                end else begin
                  state_d = (dur_q == 16'd0) ? ST_BFACT : ST_DIV_RUN;
                end
              end
            end
            OP_COLOUR: state_d = ST_BRIGHT_MUL;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV_RUN: begin
        if (cnt_q == CNT_W'(1)) state_d = ST_DIV_DONE;
      end
      ST_DIV_DONE: begin
        case (ph_q)
          DIV_PHASE: state_d = ST_BFACT;
          DIV_FLASH: state_d = ST_RESTART;
          default:   state_d = ST_DIV_RUN;
        endcase
      end
      ST_BFACT:      state_d = (kind_q == KIND_BREATHE) ? ST_SQ_MUL : ST_SHADE_MUL;
      ST_SQ_MUL:     state_d = ST_SQ_DIV;
      ST_SQ_DIV:     state_d = ST_SHADE_MUL;
      ST_SHADE_MUL:  state_d = ST_SHADE_WR;
      ST_SHADE_WR:   state_d = (ch_q == 2'd2) ? ST_RESTART : ST_SHADE_MUL;
      ST_RESTART:    state_d = ST_BRIGHT_MUL;
      ST_BRIGHT_MUL: state_d = ST_BRIGHT_WR;
      ST_BRIGHT_WR:  state_d = (ch_q == 2'd2) ? ST_OUT : ST_BRIGHT_MUL;
      ST_OUT: begin
        if (!ovalid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ph_d     = ph_q;
    bright_d = bright_q;
    period_d = period_q;
    cur_d    = cur_q;
    target_d = target_q;
    shown_d  = shown_q;
    duty_d   = duty_q;
    kind_d   = kind_q;
    dur_d    = dur_q;
    cont_d   = cont_q;
    anim_d   = anim_q;
    upd_d    = upd_q;
    e_d      = e_q;
    num_d    = num_q;
    den_d    = den_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    ch_d     = ch_q;
    t_d      = t_q;
    b_d      = b_q;
    prod_d   = {8'd0, mul_a} * {8'd0, mul_b};
    ovalid_d = ovalid_q & ~m_axis_tready;
    odata_d  = odata_q;

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_BRIGHTNESS)    bright_d = cfg_data_i;
      if (cfg_index_i == CFG_UPDATE_PERIOD) period_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        ch_d  = 2'd0;
        cnt_d = CNT_W'(NUM_W);
        rem_d = 16'd0;
        t_d   = 8'd0;
        if (in_acc) begin
          case (op)
            OP_TICK: begin
              e_d   = e_inc;
              upd_d = upd_hit ? 8'd0 : upd_inc;
              if (kind_q == KIND_FLASH) begin
                ph_d  = DIV_FLASH;
                num_d = NUM_W'(e_inc);
                den_d = {1'b0, dur_q[15:1]};
                if (upd_hit && anim_q && dur_q[15:1] == 15'd0) shown_d = target_q;
              end else begin
                ph_d  = DIV_MOD;
                num_d = NUM_W'(e_inc);
                den_d = dur_q;
              end
            end
            OP_STATUS: begin
              if (code != cur_q) begin
                cur_d       = code;
                target_d[0] = entry.r;
                target_d[1] = entry.g;
                target_d[2] = entry.b;
                kind_d      = entry.kind;
                dur_d       = entry.dur;
                cont_d      = entry.cont;
                anim_d      = (entry.kind != KIND_NONE);
                e_d         = '0;
                if (entry.kind == KIND_NONE) begin
                  shown_d[0] = entry.r;
                  shown_d[1] = entry.g;
                  shown_d[2] = entry.b;
                end
              end
            end
            OP_COLOUR: begin
              shown_d[0] = s_axis_tdata[11:4];
              shown_d[1] = s_axis_tdata[19:12];
              shown_d[2] = s_axis_tdata[27:20];
              anim_d     = 1'b0;
              kind_d     = KIND_NONE;
            end
            default: ;
          endcase
        end
      end
      ST_DIV_RUN: begin
        rem_d = qbit ? 16'(trial - {1'b0, den_q}) : trial[15:0];
        num_d = {num_q[NUM_W-2:0], qbit};
        cnt_d = cnt_q - CNT_W'(1);
      end
      ST_DIV_DONE: begin
        cnt_d = CNT_W'(NUM_W);
        rem_d = 16'd0;
        case (ph_q)
          DIV_MOD: begin
            ph_d  = DIV_PHASE;
            num_d = NUM_W'(rem_q) * NUM_W'(SINE_STEPS);
            den_d = dur_q;
          end
          DIV_PHASE: t_d = turn_prod[TURN_SH+7:TURN_SH];
          default: begin
            shown_d[0] = num_q[0] ? 8'd0 : target_q[0];
            shown_d[1] = num_q[0] ? 8'd0 : target_q[1];
            shown_d[2] = num_q[0] ? 8'd0 : target_q[2];
          end
        endcase
      end
      ST_BFACT:  b_d = pulse_sum[8:1];
      ST_SQ_DIV: b_d = div255(prod_q);
      ST_SHADE_WR: begin
        shown_d[ch_q] = div255(prod_q);
        ch_d          = (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
      end
      ST_RESTART: begin
        if (cont_q && e_q >= EW'(dur_q)) e_d = '0;
      end
      ST_BRIGHT_WR: begin
        duty_d[ch_q] = div255(prod_q);
        ch_d         = (ch_q == 2'd2) ? 2'd0 : ch_q + 2'd1;
      end
      ST_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = {duty_q[2], duty_q[1], duty_q[0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ph_q     <= DIV_MOD;
      bright_q <= BRIGHTNESS_RST;
      period_q <= UPDATE_PERIOD_RST;
      cur_q    <= 4'd0;
      target_q <= '{default: 8'd0};
      shown_q  <= '{default: 8'd0};
      kind_q   <= KIND_NONE;
      dur_q    <= 16'd0;
      cont_q   <= 1'b0;
      anim_q   <= 1'b0;
      upd_q    <= 8'd0;
      e_q      <= '0;
      cnt_q    <= '0;
      ch_q     <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ph_q     <= ph_d;
      bright_q <= bright_d;
      period_q <= period_d;
      cur_q    <= cur_d;
      target_q <= target_d;
      shown_q  <= shown_d;
      kind_q   <= kind_d;
      dur_q    <= dur_d;
      cont_q   <= cont_d;
      anim_q   <= anim_d;
      upd_q    <= upd_d;
      e_q      <= e_d;
      cnt_q    <= cnt_d;
      ch_q     <= ch_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    duty_q  <= duty_d;
    num_q   <= num_d;
    den_q   <= den_d;
    rem_q   <= rem_d;
    t_q     <= t_d;
    b_q     <= b_d;
    prod_q  <= prod_d;
    odata_q <= odata_d;
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rsla_pkg::*;

  localparam int SINE_STEPS   = 256;
  localparam int STATUS_COUNT = 11;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd2;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } duty_t;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] code;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    bit         chk;
    logic [7:0] exp_red;
    logic [7:0] exp_green;
    logic [7:0] exp_blue;
  } dir_row_t;

  // run with update period 1 so every tick yields an item
  localparam int NUM_DIR = 26;
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{OP_COLOUR, 4'd0,  8'hff, 8'hff, 8'hff, 1'b1, 8'hff, 8'hff, 8'hff},
    '{OP_COLOUR, 4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00},
    '{OP_COLOUR, 4'd0,  8'ha5, 8'h5a, 8'h0f, 1'b1, 8'ha5, 8'h5a, 8'h0f},
    '{OP_TICK,   4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 8'ha5, 8'h5a, 8'h0f},
    '{OP_SPARE,  4'd15, 8'hff, 8'hff, 8'hff, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_STATUS, 4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_TICK,   4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 8'ha5, 8'h5a, 8'h0f},
    '{OP_STATUS, 4'd3,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_TICK,   4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 8'hff, 8'hff, 8'hff},
    '{OP_STATUS, 4'd15, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_TICK,   4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00},
    '{OP_STATUS, 4'd1,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_TICK,   4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_STATUS, 4'd7,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_TICK,   4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_TICK,   4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_STATUS, 4'd2,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_TICK,   4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_STATUS, 4'd10, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_TICK,   4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_COLOUR, 4'd0,  8'h01, 8'h02, 8'h03, 1'b1, 8'h01, 8'h02, 8'h03},
    '{OP_TICK,   4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 8'h01, 8'h02, 8'h03},
    '{OP_STATUS, 4'd10, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_TICK,   4'd0,  8'h00, 8'h00, 8'h00, 1'b1, 8'h01, 8'h02, 8'h03},
    '{OP_STATUS, 4'd9,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
    '{OP_TICK,   4'd0,  8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}
  };

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [31:0]            s_axis_tdata = '0;  // status_code, red_in, green_in, blue_in
  logic [1:0]             s_axis_tuser = '0;  // operation
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [23:0]            m_axis_tdata;       // red_duty, green_duty, blue_duty
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [7:0]             cfg_data_i = '0;

  always #5 clk_i = ~clk_i;

  rgb_status_led_animator_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // animator state as the block should hold it
  logic [7:0]  lvl_brightness = BRIGHTNESS_RST;
  logic [7:0]  lvl_period     = UPDATE_PERIOD_RST;
  logic [3:0]  cur_code       = '0;
  logic [7:0]  tgt_rgb [3]    = '{8'd0, 8'd0, 8'd0};
  logic [7:0]  shown_rgb [3]  = '{8'd0, 8'd0, 8'd0};
  kind_e       anim_kind      = KIND_NONE;
  logic [15:0] anim_len       = '0;
  bit          anim_loop      = 1'b0;
  bit          anim_on        = 1'b0;
  logic [7:0]  ms_upd         = '0;
  logic [31:0] ms_run         = '0;

  duty_t duty_due [$];
  int    bad_cnt   = 0;
  bit    calm      = 1'b0;
  int    hold_asks = 0;
  int    hold_seen = 0;
  int    hold_left = 0;
  int    rcv_gap   = 0;

  function automatic int signed_sine(input int t);
    int q;
    int r;
    int v;
    q = (t >> 6) & 3;
    r = t & 63;
    v = (q & 1) ? int'(QSINE[64 - r]) : int'(QSINE[r]);
    return (q & 2) ? -v : v;
  endfunction

  function automatic logic [7:0] dim(input logic [7:0] v);
    return 8'((int'(v) * int'(lvl_brightness)) / 255);
  endfunction

  function automatic void load_status(input logic [3:0] code);
    status_entry_t ent;
    ent = STATUS_ROM[(int'(code) < STATUS_COUNT) ? int'(code) : 0];
    tgt_rgb[0] = ent.r;
    tgt_rgb[1] = ent.g;
    tgt_rgb[2] = ent.b;
    anim_kind  = ent.kind;
    anim_len   = ent.dur;
    anim_loop  = ent.cont;
    anim_on    = (ent.kind != KIND_NONE);
    ms_run     = '0;
    if (!anim_on) shown_rgb = tgt_rgb;
  endfunction

  function automatic void shade_step();
    longint unsigned e;
    longint unsigned d;
    longint unsigned k;
    longint unsigned half;
    int t;
    int b;
    int m;
    bit lit;
    e = ms_run;
    d = anim_len;
    t = 0;
    if (d != 0) begin
      k = ((e % d) * SINE_STEPS) / d;
      t = int'((k * 256) / SINE_STEPS) & 255;
    end
    if (anim_kind == KIND_FLASH) begin
      half = d / 2;
      lit = (half == 0) || (((e / half) & 64'd1) == 0);
      for (int i = 0; i < 3; i++) shown_rgb[i] = lit ? tgt_rgb[i] : 8'd0;
    end else if (anim_kind != KIND_NONE) begin
      if (anim_kind == KIND_PULSE) begin
        b = (255 + signed_sine(t)) / 2;
      end else begin
        m = signed_sine(t >> 1);
        b = (m * m) / 255;
      end
      for (int i = 0; i < 3; i++) shown_rgb[i] = 8'((int'(tgt_rgb[i]) * b) / 255);
    end
  endfunction

  function automatic void led_step(input logic [1:0] op, input logic [31:0] data,
                                   output bit emitted, output duty_t duty);
    emitted = 1'b0;
    duty = '0;
    case (op)
      OP_TICK: begin
        if (ms_upd < 8'd255) ms_upd++;
        ms_run++;
        if (ms_upd >= lvl_period) begin
          ms_upd = '0;
          if (anim_on) begin
            shade_step();
            if (anim_loop && ms_run >= 32'(anim_len)) ms_run = '0;
          end
          emitted = 1'b1;
        end
      end
      OP_STATUS: begin
        if (data[3:0] != cur_code) begin
          cur_code = data[3:0];
          load_status(cur_code);
        end
      end
      OP_COLOUR: begin
        shown_rgb[0] = data[11:4];
        shown_rgb[1] = data[19:12];
        shown_rgb[2] = data[27:20];
        anim_on = 1'b0;
        anim_kind = KIND_NONE;
        emitted = 1'b1;
      end
      default: ;
    endcase
    if (emitted) duty = {dim(shown_rgb[2]), dim(shown_rgb[1]), dim(shown_rgb[0])};
  endfunction

  function automatic logic [31:0] pack_item(input logic [3:0] code, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b);
    return {4'd0, b, g, r, code};
  endfunction

  function automatic logic [31:0] rand_item(input logic [3:0] code);
    return pack_item(code, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
  endfunction

  // entered and left at a falling edge
  task automatic push_item(input logic [1:0] op, input logic [31:0] data,
                           input bit typed, input duty_t typed_duty);
    int gap;
    bit emitted;
    duty_t duty;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    led_step(op, data, emitted, duty);
    if (emitted) duty_due.push_back(typed ? typed_duty : duty);
    @(negedge clk_i);
  endtask

  task automatic push_tick();
    push_item(OP_TICK, rand_item(4'($urandom_range(0, 15))), 1'b0, '0);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index, input logic [7:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (index)
      CFG_BRIGHTNESS:    lvl_brightness = data;
      CFG_UPDATE_PERIOD: lvl_period = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (duty_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [7:0] brt, input logic [7:0] per);
    cfg_write(CFG_BRIGHTNESS, brt);
    cfg_write(CFG_UPDATE_PERIOD, per);
  endtask

  // status select followed by a run of ticks, with some noise mixed in
  task automatic run_mix(input int budget);
    int sent;
    int len;
    int pick;
    logic [3:0] code;
    sent = 0;
    while (sent < budget) begin
      code = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 10));
      if ($urandom_range(0, 7) == 0) code = cur_code;
      push_item(OP_STATUS, rand_item(code), 1'b0, '0);
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(300, 650) : $urandom_range(1, 100);
      if (len > budget - sent - 1) len = budget - sent - 1;
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 2) push_item(OP_COLOUR, rand_item(4'($urandom_range(0, 15))), 1'b0, '0);
        else if (pick < 4) push_item(OP_SPARE, rand_item(4'($urandom_range(0, 15))), 1'b0, '0);
        else if (pick < 6) push_item(OP_STATUS, rand_item(4'($urandom_range(0, 15))), 1'b0, '0);
        else push_tick();
      end
      sent += len + 1;
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      rcv_gap = $urandom_range(1, 8) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    duty_t got;
    duty_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (duty_due.size() == 0) begin
        bad_cnt++;
        if (bad_cnt <= 10) $display("unexpected item: r=%h g=%h b=%h", got.red, got.green,
                                    got.blue);
      end else begin
        want = duty_due.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("duty mismatch: exp r=%h g=%h b=%h got r=%h g=%h b=%h",
                     want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
      end
    end
  end

  initial begin
    logic [3:0] code;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_regs(8'd255, 8'd1);
    @(negedge clk_i);
    foreach (DIR_ROWS[i]) begin
      push_item(DIR_ROWS[i].op,
                pack_item(DIR_ROWS[i].code, DIR_ROWS[i].red, DIR_ROWS[i].green,
                          DIR_ROWS[i].blue),
                DIR_ROWS[i].chk,
                {DIR_ROWS[i].exp_blue, DIR_ROWS[i].exp_green, DIR_ROWS[i].exp_red});
    end
    settle();

    set_regs(8'd255, 8'd20);
    run_mix(220);
    settle();

    set_regs(8'd0, 8'd1);
    run_mix(120);
    settle();

    cfg_write(CFG_SPARE, 8'($urandom_range(0, 255)));
    set_regs(8'd1, 8'd255);
    run_mix(220);
    settle();

    set_regs(8'($urandom_range(2, 254)), 8'd0);
    run_mix(120);
    settle();

    // receiver stalls for a long stretch while pulse updates keep coming
    set_regs(8'($urandom_range(0, 255)), 8'd1);
    code = (cur_code == 4'd2) ? 4'd4 : 4'd2;
    push_item(OP_STATUS, rand_item(code), 1'b0, '0);
    hold_asks++;
    repeat (60) push_tick();
    settle();

    // long flash run so the animation wraps its full duration
    set_regs(8'($urandom_range(0, 255)), 8'd10);
    code = (cur_code == 4'd7) ? 4'd8 : 4'd7;
    push_item(OP_STATUS, rand_item(code), 1'b0, '0);
    repeat (320) push_tick();
    settle();

    calm = 1'b1;
    set_regs(8'($urandom_range(0, 255)), 8'($urandom_range(1, 8)));
    run_mix(450);
    settle();

    if (bad_cnt == 0 && duty_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
rtl/rsla_pkg.sv
rtl/rgb_status_led_animator_core.sv
dv/tb_top.sv
